@@ rtl/lsbm_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsbm_pkg
// Shared types and constants for the line sampler with bilinear map lookup.
// ----------------------------------------------------------------------------
package lsbm_pkg;

   localparam int MAP_W_DEF   = 256;
   localparam int MAP_H_DEF   = 256;
   localparam int STORE_DEPTH = 65536;
   localparam int ADDR_W      = 16;
   localparam int PIX_W       = 16;
   localparam int SQRT_STAGES = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_START_X     = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_Y     = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_COS     = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DIR_SIN     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_NOISE_SCALE = 3'd4;

   localparam logic       REQ_WRITE  = 1'b0;
   localparam logic       REQ_SAMPLE = 1'b1;

   typedef struct packed {
      logic        req_type;
      logic [15:0] map_addr;
      logic [15:0] map_value;
      logic [16:0] distance;
   } req_beat_type;

   typedef struct packed {
      logic [15:0] mag;
      logic [15:0] mag_err;
      logic        out_of_map;
   } rsp_beat_type;

   typedef struct packed {
      logic [15:0]        start_x;
      logic [15:0]        start_y;
      logic signed [15:0] dir_cos;
      logic signed [15:0] dir_sin;
   } line_cfg_type;

   // second locate stage, as seen by the memory stage
   typedef struct packed {
      logic        vld;
      logic        samp;
      logic [15:0] wr_addr;
      logic [15:0] wr_data;
      logic        oob;
      logic [11:0] col;
      logic [11:0] row;
      logic [7:0]  fx;
      logic [7:0]  fy;
   } loc_type;

endpackage
`default_nettype wire

@@ rtl/lsbm_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsbm_ram
// Single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module lsbm_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 65536
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output      logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

@@ rtl/lsbm_isqrt.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsbm_isqrt
// Pipelined floor square root of a 32-bit value, two result bits per stage.
// ----------------------------------------------------------------------------
module lsbm_isqrt (
   input  wire logic        clock,
   input  wire logic        en,
   input  wire logic [31:0] rad,
   output      logic [15:0] root
);
   import lsbm_pkg::*;

   localparam int PER = 16 / SQRT_STAGES;

   logic [31:0] rem_ff [SQRT_STAGES];
   logic [31:0] res_ff [SQRT_STAGES];
   logic [31:0] rem_in [SQRT_STAGES];
   logic [31:0] res_in [SQRT_STAGES];

   always_comb begin
      logic [31:0] rem;
      logic [31:0] res;
      logic [31:0] bitv;
      for (int s = 0; s < SQRT_STAGES; s++) begin
         rem = (s == 0) ? rad : rem_ff[(s == 0) ? 0 : s-1];
         res = (s == 0) ? 32'd0 : res_ff[(s == 0) ? 0 : s-1];
         for (int t = 0; t < PER; t++) begin
            bitv = 32'd1 << (30 - 2 * (s * PER + t));
            if (rem >= res + bitv) begin
               rem = rem - (res + bitv);
               res = (res >> 1) + bitv;
            end else begin
               res = res >> 1;
            end
         end
         rem_in[s] = rem;
         res_in[s] = res;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int s = 0; s < SQRT_STAGES; s++) begin
            rem_ff[s] <= rem_in[s];
            res_ff[s] <= res_in[s];
         end
      end
   end

   assign root = res_ff[SQRT_STAGES-1][15:0];

endmodule
`default_nettype wire

@@ rtl/lsbm_locate.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// lsbm_locate
// Two stages: line point in Q.22, then Q12.8 cell, fraction and map bounds.
// ----------------------------------------------------------------------------
module lsbm_locate #(
   parameter int MAP_W = lsbm_pkg::MAP_W_DEF,
   parameter int MAP_H = lsbm_pkg::MAP_H_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  en,
   input  wire logic                  in_vld,
   input  wire lsbm_pkg::req_beat_type in_beat,
   input  wire lsbm_pkg::line_cfg_type cfg,
   output      lsbm_pkg::loc_type     loc
);
   import lsbm_pkg::*;

   logic               vld1_ff;
   req_beat_type       beat1_ff;
   logic signed [34:0] px_ff, py_ff;
   logic signed [33:0] mx, my;
   logic signed [34:0] px_in, py_in;
   loc_type            loc_ff, loc_in;
   logic [19:0]        x8, y8;

   always_comb begin
      mx    = $signed({1'b0, in_beat.distance}) * cfg.dir_cos;
      my    = $signed({1'b0, in_beat.distance}) * cfg.dir_sin;
      px_in = $signed({5'b0, cfg.start_x, 14'b0}) + $signed({mx[33], mx});
      py_in = $signed({5'b0, cfg.start_y, 14'b0}) + $signed({my[33], my});
   end

   always_comb begin
      x8             = px_ff[33:14];
      y8             = py_ff[33:14];
      loc_in.vld     = vld1_ff;
      loc_in.samp    = (beat1_ff.req_type == REQ_SAMPLE);
      loc_in.wr_addr = beat1_ff.map_addr;
      loc_in.wr_data = beat1_ff.map_value;
      loc_in.col     = x8[19:8];
      loc_in.row     = y8[19:8];
      loc_in.fx      = x8[7:0];
      loc_in.fy      = y8[7:0];
      loc_in.oob     = px_ff[34] || py_ff[34]
                       || ({1'b0, x8[19:8]} + 13'd1 >= 13'(MAP_W))
                       || ({1'b0, y8[19:8]} + 13'd1 >= 13'(MAP_H));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld1_ff    <= 1'b0;
         loc_ff.vld <= 1'b0;
      end else if (en) begin
         vld1_ff    <= in_vld;
         loc_ff.vld <= loc_in.vld;
      end
      if (en) begin
         beat1_ff     <= in_beat;
         px_ff        <= px_in;
         py_ff        <= py_in;
         loc_ff.samp    <= loc_in.samp;
         loc_ff.wr_addr <= loc_in.wr_addr;
         loc_ff.wr_data <= loc_in.wr_data;
         loc_ff.oob     <= loc_in.oob;
         loc_ff.col     <= loc_in.col;
         loc_ff.row     <= loc_in.row;
         loc_ff.fx      <= loc_in.fx;
         loc_ff.fy      <= loc_in.fy;
      end
   end

   assign loc = loc_ff;

endmodule
`default_nettype wire

@@ rtl/line_sampler_bilinear_map.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// line_sampler_bilinear_map
// Samples a stored Q8.8 map along a configured line with bilinear weights.
// ----------------------------------------------------------------------------
// A beat can be accepted every clock unless a stalled result holds the
// pipeline. A sample beat passes through the locate stages, the four map
// copies (one read port each), the product stage, the eight-stage square root
// pipeline and the final weighting and rounding stages. Write beats update all
// four map copies and give no result. The map is undefined until written. A
// stalled result holds the whole pipeline.
module line_sampler_bilinear_map #(
   parameter int MAP_W = lsbm_pkg::MAP_W_DEF,
   parameter int MAP_H = lsbm_pkg::MAP_H_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire lsbm_pkg::req_beat_type               req_data,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      lsbm_pkg::rsp_beat_type               rsp_data,
   input  wire logic                                csr_wr_en,
   input  wire logic [lsbm_pkg::CSR_IDX_W-1:0]      csr_index,
   input  wire logic [lsbm_pkg::CSR_DATA_W-1:0]     csr_wr_data
);
   import lsbm_pkg::*;

   localparam int LAST = 14;

   logic         en;
   line_cfg_type cfg_ff;
   logic [15:0]  noise_ff;
   loc_type      loc;

   logic [LAST:3] vld_ff;
   logic [13:3]   oob_ff;
   logic [16:0]   wt_ff  [3:12][4];
   logic [16:0]   wt_in  [4];
   logic [15:0]   addr_in [4];
   logic [15:0]   pix    [4];
   logic [32:0]   pm_ff  [4];
   logic [31:0]   pn_ff  [4];
   logic [15:0]   root   [4];
   logic [32:0]   pe_ff  [4];
   logic [15:0]   mag_ff [5:13];
   logic [15:0]   mag_in;
   logic [34:0]   sum_m, sum_e;
   rsp_beat_type  rsp_ff, rsp_in;
   logic [8:0]    wx0, wy0;
   logic [16:0]   rnd_m, rnd_e;

   assign en        = !vld_ff[LAST] || rsp_ready;
   assign req_ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.start_x <= 16'd0;
         cfg_ff.start_y <= 16'd0;
         cfg_ff.dir_cos <= 16'sd16384;
         cfg_ff.dir_sin <= 16'sd0;
         noise_ff       <= 16'd256;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_START_X:     cfg_ff.start_x <= csr_wr_data;
            CSR_START_Y:     cfg_ff.start_y <= csr_wr_data;
            CSR_DIR_COS:     cfg_ff.dir_cos <= $signed(csr_wr_data);
            CSR_DIR_SIN:     cfg_ff.dir_sin <= $signed(csr_wr_data);
            CSR_NOISE_SCALE: noise_ff       <= csr_wr_data;
            default: ;
         endcase
      end
   end

   lsbm_locate #(.MAP_W(MAP_W), .MAP_H(MAP_H)) u_locate (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_valid),
      .in_beat (req_data),
      .cfg     (cfg_ff),
      .loc     (loc)
   );

   always_comb begin
      wx0        = 9'd256 - {1'b0, loc.fx};
      wy0        = 9'd256 - {1'b0, loc.fy};
      wt_in[0]   = 17'(wx0 * wy0);
      wt_in[1]   = 17'({1'b0, loc.fx} * wy0);
      wt_in[2]   = 17'(wx0 * {1'b0, loc.fy});
      wt_in[3]   = 17'({1'b0, loc.fx} * {1'b0, loc.fy});
      addr_in[0] = 16'(32'(loc.row) * 32'(MAP_W) + 32'(loc.col));
      addr_in[1] = addr_in[0] + 16'd1;
      addr_in[2] = addr_in[0] + 16'(MAP_W);
      addr_in[3] = addr_in[2] + 16'd1;
   end

   for (genvar k = 0; k < 4; k++) begin : g_lane
      lsbm_ram #(.WIDTH(PIX_W), .DEPTH(STORE_DEPTH)) u_ram (
         .clock   (clock),
         .wr_en   (en && loc.vld && !loc.samp),
         .wr_addr (loc.wr_addr),
         .wr_data (loc.wr_data),
         .rd_en   (en),
         .rd_addr (addr_in[k]),
         .rd_data (pix[k])
      );

      lsbm_isqrt u_isqrt (
         .clock (clock),
         .en    (en),
         .rad   (pn_ff[k]),
         .root  (root[k])
      );
   end

   always_comb begin
      sum_m  = 35'(pm_ff[0]) + 35'(pm_ff[1]) + 35'(pm_ff[2]) + 35'(pm_ff[3]) + 35'd32768;
      rnd_m  = sum_m[32:16] ;
      mag_in = (oob_ff[4]) ? 16'd0 : ((|sum_m[34:32]) ? 16'hFFFF : rnd_m[15:0]);
      sum_e  = 35'(pe_ff[0]) + 35'(pe_ff[1]) + 35'(pe_ff[2]) + 35'(pe_ff[3]) + 35'd32768;
      rnd_e  = sum_e[32:16];
      rsp_in.mag        = mag_ff[13];
      rsp_in.out_of_map = oob_ff[13];
      rsp_in.mag_err    = oob_ff[13] ? 16'd0 : ((|sum_e[34:32]) ? 16'hFFFF : rnd_e[15:0]);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff[3] <= loc.vld && loc.samp;
         for (int s = 4; s <= LAST; s++) begin
            vld_ff[s] <= vld_ff[s-1];
         end
      end
      if (en) begin
         oob_ff[3] <= loc.oob;
         for (int s = 4; s <= 13; s++) begin
            oob_ff[s] <= oob_ff[s-1];
         end
         for (int k = 0; k < 4; k++) begin
            wt_ff[3][k] <= wt_in[k];
            for (int s = 4; s <= 12; s++) begin
               wt_ff[s][k] <= wt_ff[s-1][k];
            end
            pm_ff[k] <= pix[k] * wt_ff[3][k];
            pn_ff[k] <= pix[k] * noise_ff;
            pe_ff[k] <= root[k] * wt_ff[12][k];
         end
         mag_ff[5] <= mag_in;
         for (int s = 6; s <= 13; s++) begin
            mag_ff[s] <= mag_ff[s-1];
         end
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = vld_ff[LAST];
   assign rsp_data  = rsp_ff;

endmodule
`default_nettype wire

@@ sim/testbench.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// testbench
// Drives map write and line sample beats into line_sampler_bilinear_map across
// a series of line and noise settings. Each sample is predicted from a local
// map image and register copy, and each result is checked in order.
// ----------------------------------------------------------------------------
module testbench;
   import lsbm_pkg::*;

   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_SPARE_HI = 3'd7;
   localparam int MAP_W = MAP_W_DEF;
   localparam int MAP_H = MAP_H_DEF;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   req_beat_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_beat_type rsp_data;
   logic csr_wr_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wr_data = '0;

   req_beat_type pending_beats[$];
   rsp_beat_type expected_samples[$];
   logic [15:0] map_image[STORE_DEPTH];
   bit map_loaded[STORE_DEPTH];
   logic [15:0] line_sx = 16'd0;
   logic [15:0] line_sy = 16'd0;
   logic signed [15:0] line_cos = 16'sd16384;
   logic signed [15:0] line_sin = 16'sd0;
   logic [15:0] noise_gain = 16'd256;
   int send_idle_pct = 0;
   int rcv_stall_pct = 0;
   int hold_cycles = 0;
   int mismatch_cnt = 0;

   line_sampler_bilinear_map u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   always #1 clock = ~clock;

   function automatic longint root_floor(input longint v);
      longint r, t;
      r = 0;
      for (int b = 16; b >= 0; b--) begin
         t = r | (longint'(1) << b);
         if (t * t <= v) r = t;
      end
      return r;
   endfunction

   function automatic bit locate_point(input logic [16:0] run_len, output longint col,
                                       output longint row, output longint fx,
                                       output longint fy);
      longint px, py;
      px = longint'(line_sx) * 16384 + longint'(run_len) * longint'(line_cos);
      py = longint'(line_sy) * 16384 + longint'(run_len) * longint'(line_sin);
      col = 0; row = 0; fx = 0; fy = 0;
      if (px < 0 || py < 0) return 1'b0;
      px = px >>> 14;
      py = py >>> 14;
      col = px >>> 8;
      row = py >>> 8;
      fx = px & 255;
      fy = py & 255;
      return (col + 1 < MAP_W) && (row + 1 < MAP_H);
   endfunction

   function automatic logic [15:0] corner_addr(input longint col, input longint row,
                                               input int k);
      return 16'((row + (k / 2)) * MAP_W + col + (k % 2));
   endfunction

   function automatic rsp_beat_type sample_line(input logic [16:0] run_len);
      rsp_beat_type r;
      longint col, row, fx, fy, pix, acc_mag, acc_err;
      longint wt[4];
      r = '{mag: 16'd0, mag_err: 16'd0, out_of_map: 1'b1};
      if (!locate_point(run_len, col, row, fx, fy)) return r;
      wt[0] = (256 - fx) * (256 - fy);
      wt[1] = fx * (256 - fy);
      wt[2] = (256 - fx) * fy;
      wt[3] = fx * fy;
      acc_mag = 0;
      acc_err = 0;
      for (int k = 0; k < 4; k++) begin
         pix = longint'(map_image[corner_addr(col, row, k)]);
         acc_mag += pix * wt[k];
         acc_err += root_floor(pix * longint'(noise_gain)) * wt[k];
      end
      acc_mag = (acc_mag + 32768) >>> 16;
      acc_err = (acc_err + 32768) >>> 16;
      r.mag = acc_mag > 65535 ? 16'hFFFF : 16'(acc_mag);
      r.mag_err = acc_err > 65535 ? 16'hFFFF : 16'(acc_err);
      r.out_of_map = 1'b0;
      return r;
   endfunction

   task automatic queue_write(input logic [15:0] addr, input logic [15:0] value);
      req_beat_type b;
      b.req_type = REQ_WRITE;
      b.map_addr = addr;
      b.map_value = value;
      b.distance = 17'($urandom);
      pending_beats = {pending_beats, b};
      map_loaded[addr] = 1'b1;
   endtask

   // load any unwritten corner first so no sample reads an undefined pixel
   task automatic queue_sample(input logic [16:0] run_len);
      req_beat_type b;
      longint col, row, fx, fy;
      logic [15:0] a;
      if (locate_point(run_len, col, row, fx, fy))
         for (int k = 0; k < 4; k++) begin
            a = corner_addr(col, row, k);
            if (!map_loaded[a]) queue_write(a, 16'($urandom));
         end
      b.req_type = REQ_SAMPLE;
      b.map_addr = 16'($urandom);
      b.map_value = 16'($urandom);
      b.distance = run_len;
      pending_beats = {pending_beats, b};
   endtask

   task automatic csr_write(input logic [CSR_IDX_W-1:0] idx, input logic [15:0] value);
      @(posedge clock);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      case (idx)
         CSR_START_X:     line_sx = value;
         CSR_START_Y:     line_sy = value;
         CSR_DIR_COS:     line_cos = value;
         CSR_DIR_SIN:     line_sin = value;
         CSR_NOISE_SCALE: noise_gain = value;
         default: ;
      endcase
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   task automatic set_line(input logic [15:0] sx, input logic [15:0] sy,
                           input logic [15:0] c, input logic [15:0] s,
                           input logic [15:0] ns);
      csr_write(CSR_START_X, sx);
      csr_write(CSR_START_Y, sy);
      csr_write(CSR_DIR_COS, c);
      csr_write(CSR_DIR_SIN, s);
      csr_write(CSR_NOISE_SCALE, ns);
   endtask

   task automatic drain();
      while (pending_beats.size() != 0 || req_valid || expected_samples.size() != 0)
         @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready) begin
            if (req_data.req_type == REQ_WRITE)
               map_image[req_data.map_addr] = req_data.map_value;
            else
               expected_samples = {expected_samples, sample_line(req_data.distance)};
         end
         if (!req_valid || req_ready) begin
            if (pending_beats.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_valid <= 1'b1;
               req_data <= pending_beats.pop_front();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      rsp_beat_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_samples.size() == 0) begin
            mismatch_cnt++;
            if (mismatch_cnt <= 10) $display("unexpected result beat %p", rsp_data);
         end else begin
            want = expected_samples.pop_front();
            if (rsp_data !== want) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("mismatch: expected mag %h err %h oom %b, got mag %h err %h oom %b",
                           want.mag, want.mag_err, want.out_of_map,
                           rsp_data.mag, rsp_data.mag_err, rsp_data.out_of_map);
            end
         end
      end
      if (hold_cycles > 0) begin
         hold_cycles <= hold_cycles - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= $urandom_range(99) >= rcv_stall_pct;
      end
   end

   initial begin
      #2000000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   initial begin
      logic [16:0] d;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);
      send_idle_pct = 20;
      rcv_stall_pct = 49;

      // reset line: along row 0 to the right edge
      queue_write(16'h0000, 16'hFFFF);
      queue_write(16'hFFFF, 16'h0000);
      queue_write(16'h0001, 16'h0000);
      queue_write(16'h0100, 16'hFFFF);
      queue_write(16'h0101, 16'h8000);
      queue_sample(17'd0);
      queue_sample(17'd128);
      queue_sample(17'd255);
      queue_sample(17'(254 * 256 + 255));
      queue_sample(17'(255 * 256));
      queue_sample(17'h1FFFF);
      drain();

      set_line(16'h0380, 16'h0240, 16'sd11585, 16'sd11585, 16'hFFFF);
      @(negedge clock);
      queue_sample(17'd0);
      queue_sample(17'd77);
      queue_sample(17'd1000);
      queue_sample(17'h1FFFF);
      drain();

      set_line(16'hFFFF, 16'h0000, -16'sd16384, 16'sd16384, 16'h0000);
      @(negedge clock);
      queue_sample(17'd0);
      queue_sample(17'd200);
      queue_sample(17'd300);
      queue_sample(17'h1FFFF);
      drain();

      // direction beyond unit length, and spare register indexes
      set_line(16'h8000, 16'h8000, 16'h8000, 16'h7FFF, 16'h0001);
      csr_write(CSR_SPARE_LO, 16'hFFFF);
      csr_write(CSR_SPARE_HI, 16'h1234);
      @(negedge clock);
      queue_sample(17'd0);
      queue_sample(17'd100);
      queue_sample(17'd50);
      drain();

      for (int ph = 0; ph < 9; ph++) begin
         if (ph == 3) begin
            send_idle_pct = 49;
            rcv_stall_pct = 20;
         end else if (ph == 6) begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         if (ph == 8)
            set_line(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom),
                     16'($urandom));
         else
            set_line(16'($urandom_range(0, 240 * 256)), 16'($urandom_range(0, 240 * 256)),
                     16'($signed($urandom_range(0, 32768)) - 16384),
                     16'($signed($urandom_range(0, 32768)) - 16384),
                     16'($urandom));
         @(negedge clock);
         for (int n = 0; n < 70; n++) begin
            case ($urandom_range(9))
               0: queue_write(16'($urandom), 16'($urandom));
               1, 2: queue_sample(17'($urandom));
               default: begin
                  d = 17'($urandom_range(0, 16 * 256));
                  queue_sample(d);
               end
            endcase
         end
         if (ph == 7) hold_cycles = 400;
         drain();
      end

      repeat (30) @(posedge clock);
      if (mismatch_cnt == 0 && expected_samples.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
`default_nettype wire
